>>> hw/rtl/linked_multi_queue_compacting_macros.svh
// Assertion helpers for the linked multi-queue.
`ifndef LINKED_MULTI_QUEUE_COMPACTING_MACROS_SVH
`define LINKED_MULTI_QUEUE_COMPACTING_MACROS_SVH
`define LMQ_ASSERT_IMP(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("assertion failed");
`define LMQ_ASSERT_NEXT(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("assertion failed");
`endif

>>> hw/rtl/lmqc_pkg.sv
package lmqc_pkg;
   typedef enum logic [1:0] {
      CMD_CREATE  = 2'd0,
      CMD_DESTROY = 2'd1,
      CMD_ENQ     = 2'd2,
      CMD_DEQ     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_ID   = 3'd1,
      ST_INACTIVE = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FULL     = 3'd4,
      ST_NO_QUEUE = 3'd5
   } status_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [5:0] queue_id;
      logic [7:0] value;
   } item_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DECIDE,
      BK_ENQ_RD,
      BK_ENQ_WR,
      BK_POP_RD,
      BK_POP_LAST,
      BK_POP_FIX1,
      BK_POP_FIX2,
      BK_POP_QFIX,
      BK_POP_QSCAN,
      BK_RESULT
   } back_state_type;
endpackage

>>> hw/rtl/lmqc_front.sv
module lmqc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [5:0]          req_queue_id,
   input  logic [7:0]          req_value,
   output logic                q_valid,
   input  logic                q_pop,
   output lmqc_pkg::item_type  q_item
);
   import lmqc_pkg::*;

   item_type   buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push;

   assign req_stall = cnt_ff == 2'd2;
   assign push      = req_valid && !req_stall;
   assign q_valid   = cnt_ff != 2'd0;
   assign q_item    = buf_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = q_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= '{cmd: cmd_type'(req_cmd), queue_id: req_queue_id, value: req_value};
      end
   end
endmodule

>>> hw/rtl/lmqc_back.sv
module lmqc_back #(
   parameter int NUM_QUEUES = 16,
   parameter int NODE_SLOTS = 512
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_pop,
   input  lmqc_pkg::item_type q_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_created_id,
   output logic [7:0]         rsp_data_out,
   output logic [9:0]         rsp_total_count
);
   import lmqc_pkg::*;
   `include "linked_multi_queue_compacting_macros.svh"

   localparam int AW = $clog2(NODE_SLOTS);
   localparam int LW = $clog2(NODE_SLOTS + 1);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam logic [LW-1:0] NIL = LW'(NODE_SLOTS);

   logic [7:0]    mem_byte [NODE_SLOTS];
   logic [LW-1:0] mem_prev [NODE_SLOTS];
   logic [LW-1:0] mem_next [NODE_SLOTS];

   logic [NUM_QUEUES-1:0] act_ff, act_in, ne_ff, ne_in;
   logic [AW-1:0] head_ff [NUM_QUEUES];
   logic [AW-1:0] tail_ff [NUM_QUEUES];
   logic [LW-1:0] used_ff, used_in;

   back_state_type st_ff, st_in;
   item_type       it_ff;
   logic [QW-1:0]  q_ff;
   logic [AW-1:0]  gap_ff, last_ff;
   logic [7:0]     rd_byte_ff;
   logic [LW-1:0]  rd_prev_ff, rd_next_ff;
   logic [7:0]     got_ff;
   logic           dest_ff;

   logic           rv_ff;
   logic [2:0]     rst_ff;
   logic [5:0]     rcid_ff;
   logic [7:0]     rdat_ff;

   logic [AW-1:0]  raddr;
   logic [AW-1:0]  waddr;
   logic [7:0]     wbyte;
   logic [LW-1:0]  wprev, wnext;
   logic           wb_en, wp_en, wn_en;
   logic [QW-1:0]  free_idx;
   logic           free_any;
   logic           in_range;
   logic [QW-1:0]  qid;

   assign qid      = it_ff.queue_id[QW-1:0];
   assign in_range = {26'd0, it_ff.queue_id} < NUM_QUEUES;
   assign q_pop    = q_valid && st_ff == BK_IDLE && !rv_ff;

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            free_any = 1'b1;
            free_idx = QW'(i);
         end
      end
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE:     if (q_pop) st_in = BK_DECIDE;
         BK_DECIDE: begin
            st_in = BK_RESULT;
            if (it_ff.cmd == CMD_ENQ && in_range && act_ff[qid] && used_ff < NIL) begin
               st_in = BK_ENQ_WR;
            end else if (it_ff.cmd == CMD_DEQ && in_range && act_ff[qid] && ne_ff[qid]
                         && used_ff != '0) begin
               st_in = BK_POP_RD;
            end else if (it_ff.cmd == CMD_DESTROY && in_range && act_ff[qid]
                         && ne_ff[qid] && used_ff != '0) begin
               st_in = BK_POP_RD;
            end
         end
         BK_ENQ_WR:   st_in = BK_RESULT;
         BK_ENQ_RD:   st_in = BK_RESULT;
         BK_POP_RD:   st_in = BK_POP_LAST;
         BK_POP_LAST: st_in = (last_ff != gap_ff) ? BK_POP_FIX1 : BK_POP_QFIX;
         BK_POP_FIX1: st_in = BK_POP_FIX2;
         BK_POP_FIX2: st_in = BK_POP_QFIX;
         BK_POP_QFIX: st_in = BK_POP_QSCAN;
         BK_POP_QSCAN: begin
            if (dest_ff && ne_ff[q_ff] && used_ff != '0) st_in = BK_POP_RD;
            else st_in = BK_RESULT;
         end
         BK_RESULT:   st_in = BK_IDLE;
         default:     st_in = BK_IDLE;
      endcase
   end

   always_comb begin
      raddr = gap_ff;
      case (st_ff)
         BK_POP_RD:   raddr = head_ff[q_ff];
         BK_POP_LAST: raddr = last_ff;
         BK_POP_FIX1: raddr = last_ff;
         BK_POP_FIX2: raddr = last_ff;
         default:     raddr = gap_ff;
      endcase
   end

   always_comb begin
      wb_en = 1'b0; wp_en = 1'b0; wn_en = 1'b0;
      waddr = gap_ff; wbyte = rd_byte_ff; wprev = rd_prev_ff; wnext = rd_next_ff;
      case (st_ff)
         BK_DECIDE: begin
            if (it_ff.cmd == CMD_ENQ && in_range && act_ff[qid] && used_ff < NIL) begin
               waddr = used_ff[AW-1:0];
               wbyte = it_ff.value;
               wnext = NIL;
               wprev = ne_ff[qid] ? LW'(tail_ff[qid]) : NIL;
               wb_en = 1'b1; wp_en = 1'b1; wn_en = 1'b1;
            end
         end
         BK_ENQ_WR: begin
            if (ne_ff[q_ff] && tail_ff[q_ff] != used_ff[AW-1:0]) begin
               waddr = tail_ff[q_ff];
               wnext = used_ff;
               wn_en = 1'b1;
            end
         end
         BK_POP_LAST: begin
            if (rd_next_ff < NIL) begin
               waddr = rd_next_ff[AW-1:0];
               wprev = NIL;
               wp_en = 1'b1;
            end
         end
         BK_POP_FIX1: begin
            waddr = gap_ff;
            wb_en = 1'b1; wp_en = 1'b1; wn_en = 1'b1;
            wprev = (rd_prev_ff == LW'(gap_ff)) ? NIL : rd_prev_ff;
            wnext = rd_next_ff;
         end
         BK_POP_FIX2: begin
            if (rd_prev_ff < NIL) begin
               waddr = rd_prev_ff[AW-1:0];
               wnext = LW'(gap_ff);
               wn_en = 1'b1;
            end
         end
         BK_POP_QFIX: begin
            if (last_ff != gap_ff && rd_next_ff < NIL) begin
               waddr = rd_next_ff[AW-1:0];
               wprev = LW'(gap_ff);
               wp_en = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wb_en) mem_byte[waddr] <= wbyte;
      if (wp_en) mem_prev[waddr] <= wprev;
      if (wn_en) mem_next[waddr] <= wnext;
      rd_byte_ff <= mem_byte[raddr];
      rd_prev_ff <= mem_prev[raddr];
      rd_next_ff <= mem_next[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= BK_IDLE;
         act_ff  <= '0;
         ne_ff   <= '0;
         used_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (st_ff == BK_RESULT) rv_ff <= 1'b1;
         if (q_pop) it_ff <= q_item;
         case (st_ff)
            BK_DECIDE: begin
               q_ff    <= qid;
               dest_ff <= it_ff.cmd == CMD_DESTROY;
               rcid_ff <= '0;
               rdat_ff <= '0;
               rst_ff  <= ST_OK;
               if (it_ff.cmd == CMD_CREATE) begin
                  if (free_any) begin
                     act_ff[free_idx] <= 1'b1;
                     ne_ff[free_idx]  <= 1'b0;
                     rcid_ff <= 6'(free_idx);
                  end else rst_ff <= ST_NO_QUEUE;
               end else if (!in_range) begin
                  rst_ff <= ST_BAD_ID;
                  if (it_ff.cmd == CMD_DEQ) rdat_ff <= 8'hff;
               end else if (it_ff.cmd == CMD_DESTROY) begin
                  if (act_ff[qid] && !(ne_ff[qid] && used_ff != '0)) begin
                     act_ff[qid] <= 1'b0;
                     ne_ff[qid]  <= 1'b0;
                  end
               end else if (it_ff.cmd == CMD_ENQ) begin
                  if (!act_ff[qid]) rst_ff <= ST_INACTIVE;
                  else if (used_ff >= NIL) rst_ff <= ST_FULL;
               end else begin
                  if (!act_ff[qid]) begin
                     rst_ff <= ST_INACTIVE; rdat_ff <= 8'hff;
                  end else if (!ne_ff[qid] || used_ff == '0) begin
                     rst_ff <= ST_EMPTY; rdat_ff <= 8'hff;
                  end
               end
            end
            BK_ENQ_WR: begin
               if (!ne_ff[q_ff]) head_ff[q_ff] <= used_ff[AW-1:0];
               ne_ff[q_ff]   <= 1'b1;
               tail_ff[q_ff] <= used_ff[AW-1:0];
               used_ff       <= used_ff + 1'b1;
            end
            BK_POP_RD: begin
               gap_ff  <= head_ff[q_ff];
               last_ff <= AW'(used_ff - 1'b1);
            end
            BK_POP_LAST: begin
               got_ff   <= rd_byte_ff;
               if (rd_next_ff >= NIL) ne_ff[q_ff] <= 1'b0;
               else head_ff[q_ff] <= rd_next_ff[AW-1:0];
            end
            BK_POP_QFIX: begin
               if (last_ff != gap_ff) begin
                  for (int i = 0; i < NUM_QUEUES; i++) begin
                     if (act_ff[i] && ne_ff[i]) begin
                        if (head_ff[i] == last_ff) head_ff[i] <= gap_ff;
                        if (tail_ff[i] == last_ff) tail_ff[i] <= gap_ff;
                     end
                  end
               end
               used_ff <= used_ff - 1'b1;
            end
            BK_POP_QSCAN: begin
               if (!dest_ff) rdat_ff <= got_ff;
               else if (!(ne_ff[q_ff] && used_ff != '0)) begin
                  act_ff[q_ff] <= 1'b0;
                  ne_ff[q_ff]  <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = rst_ff;
   assign rsp_ok          = rst_ff == ST_OK;
   assign rsp_created_id  = rcid_ff;
   assign rsp_data_out    = rdat_ff;
   assign rsp_total_count = 10'(used_ff);

   `LMQ_ASSERT_IMP(a_used_bound, 1'b1, used_ff <= NIL)
   `LMQ_ASSERT_IMP(a_pop_idle, q_pop, st_ff == BK_IDLE)
   `LMQ_ASSERT_NEXT(a_res_valid, st_ff == BK_RESULT, rv_ff)
endmodule

>>> hw/rtl/linked_multi_queue_compacting.sv
// Channel | Dir | Ports
// req     | in  | req_valid, req_stall, req_cmd, req_queue_id, req_value
// rsp     | out | rsp_valid, rsp_stall, rsp_ok, rsp_status, rsp_created_id,
//         |     | rsp_data_out, rsp_total_count
// Create, bad id and errors go from decide straight to the result state; enqueue adds
// one link-write state; dequeue reads, unlinks the head, moves the last used node into
// the gap (skipped when the head is the last used node) and repairs queue pointers.
// Destroy repeats the dequeue sequence for each node removed.
// Reset clears queue flags and node count; node store needs no clearing.
// A stalled response holds the back end; a two-entry queue keeps taking input until it fills.
module linked_multi_queue_compacting #(
   parameter int NUM_QUEUES = 16,
   parameter int NODE_SLOTS = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [5:0] req_queue_id,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_ok,
   output logic [2:0] rsp_status,
   output logic [5:0] rsp_created_id,
   output logic [7:0] rsp_data_out,
   output logic [9:0] rsp_total_count
);
   import lmqc_pkg::*;

   logic     q_valid, q_pop;
   item_type q_item;

   lmqc_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .req_queue_id, .req_value,
      .q_valid, .q_pop, .q_item
   );

   lmqc_back #(.NUM_QUEUES(NUM_QUEUES), .NODE_SLOTS(NODE_SLOTS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item,
      .rsp_valid, .rsp_stall, .rsp_ok, .rsp_status, .rsp_created_id,
      .rsp_data_out, .rsp_total_count
   );
endmodule

>>> sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lmqc_pkg::*;

   localparam int NQ = 16;
   localparam int NS = 512;
   localparam int NIL = NS;

   typedef struct packed {
      logic       ok;
      logic [2:0] status;
      logic [5:0] created_id;
      logic [7:0] data_out;
      logic [9:0] total_count;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic [5:0] req_queue_id = '0;
   logic [7:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_ok;
   logic [2:0] rsp_status;
   logic [5:0] rsp_created_id;
   logic [7:0] rsp_data_out;
   logic [9:0] rsp_total_count;

   linked_multi_queue_compacting #(.NUM_QUEUES(NQ), .NODE_SLOTS(NS)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the queue store
   bit        q_active [NQ];
   bit        q_nonempty [NQ];
   int        q_head [NQ];
   int        q_tail [NQ];
   bit [7:0]  n_byte [NS];
   int        n_prev [NS];
   int        n_next [NS];
   int        used;

   item_type  pending_cmds [$];
   reply_type expected_replies [$];
   int        mismatches = 0;
   bit        sending_done = 1'b0;
   int        hold_cycles = 0;
   int        gap_in = 0;
   int        gap_out = 0;

   function automatic bit [7:0] unlink_head(int q);
      int gap, after, last, lp, ln;
      bit [7:0] got;
      gap = q_head[q];
      got = n_byte[gap];
      after = n_next[gap];
      if (after >= NIL) begin
         q_nonempty[q] = 1'b0;
      end else begin
         q_head[q] = after;
         n_prev[after] = NIL;
      end
      last = used - 1;
      if (last != gap) begin
         lp = n_prev[last];
         ln = n_next[last];
         n_byte[gap] = n_byte[last];
         n_prev[gap] = lp;
         n_next[gap] = ln;
         if (lp < NIL) n_next[lp] = gap;
         if (ln < NIL) n_prev[ln] = gap;
         for (int i = 0; i < NQ; i++) begin
            if (q_active[i] && q_nonempty[i]) begin
               if (q_head[i] == last) q_head[i] = gap;
               if (q_tail[i] == last) q_tail[i] = gap;
            end
         end
      end
      used--;
      return got;
   endfunction

   function automatic reply_type apply_command(item_type it);
      reply_type r;
      status_type st;
      int q;
      st = ST_OK;
      q = it.queue_id;
      r = '0;
      if (it.cmd == CMD_CREATE) begin
         st = ST_NO_QUEUE;
         for (int i = 0; i < NQ; i++) begin
            if (!q_active[i]) begin
               q_active[i] = 1'b1;
               q_nonempty[i] = 1'b0;
               r.created_id = 6'(i);
               st = ST_OK;
               break;
            end
         end
      end else if (q >= NQ) begin
         st = ST_BAD_ID;
         if (it.cmd == CMD_DEQ) r.data_out = 8'hFF;
      end else if (it.cmd == CMD_DESTROY) begin
         if (q_active[q]) begin
            while (q_nonempty[q] && used > 0) void'(unlink_head(q));
            q_nonempty[q] = 1'b0;
            q_active[q] = 1'b0;
         end
      end else if (it.cmd == CMD_ENQ) begin
         if (!q_active[q]) begin
            st = ST_INACTIVE;
         end else if (used >= NS) begin
            st = ST_FULL;
         end else begin
            n_byte[used] = it.value;
            n_next[used] = NIL;
            if (q_nonempty[q]) begin
               n_prev[used] = q_tail[q];
               n_next[q_tail[q]] = used;
            end else begin
               n_prev[used] = NIL;
               q_head[q] = used;
               q_nonempty[q] = 1'b1;
            end
            q_tail[q] = used;
            used++;
         end
      end else begin
         if (!q_active[q]) begin
            st = ST_INACTIVE;
            r.data_out = 8'hFF;
         end else if (!q_nonempty[q] || used == 0) begin
            st = ST_EMPTY;
            r.data_out = 8'hFF;
         end else begin
            r.data_out = unlink_head(q);
         end
      end
      r.ok = (st == ST_OK);
      r.status = st;
      r.total_count = 10'(used);
      return r;
   endfunction

   task automatic add_cmd(cmd_type c, int q, int v);
      item_type it;
      it.cmd = c;
      it.queue_id = 6'(q);
      it.value = 8'(v);
      pending_cmds.push_back(it);
   endtask

   function automatic int pick_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // driver
   always @(posedge clock) begin
      item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            it = pending_cmds.pop_front();
            expected_replies.push_back(apply_command(it));
            if (pending_cmds.size() == 0) sending_done <= 1'b1;
            gap_in = pick_gap();
         end
         if (!(req_valid && req_stall)) begin
            if (gap_in > 0 || pending_cmds.size() == 0) begin
               if (gap_in > 0) gap_in--;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_cmd <= pending_cmds[0].cmd;
               req_queue_id <= pending_cmds[0].queue_id;
               req_value <= pending_cmds[0].value;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      reply_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_ok, rsp_status, rsp_created_id, rsp_data_out, rsp_total_count};
            if (expected_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer %p", got);
            end else begin
               want = expected_replies.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else if (gap_out > 0) begin
            gap_out--;
            rsp_stall <= 1'b1;
         end else begin
            gap_out = pick_gap();
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int q, v, r;
      for (int i = 0; i < 17; i++) add_cmd(CMD_CREATE, 0, 0);
      add_cmd(CMD_ENQ, 0, 8'h00);
      add_cmd(CMD_ENQ, 15, 8'hFF);
      add_cmd(CMD_ENQ, 0, 8'hA5);
      add_cmd(CMD_DEQ, 0, 0);
      add_cmd(CMD_DEQ, 63, 0);
      add_cmd(CMD_ENQ, 16, 8'h5A);
      add_cmd(CMD_DESTROY, 42, 0);
      add_cmd(CMD_DESTROY, 15, 0);
      add_cmd(CMD_DEQ, 15, 0);
      add_cmd(CMD_ENQ, 15, 1);
      add_cmd(CMD_DESTROY, 15, 0);
      add_cmd(CMD_DEQ, 1, 0);
      // fill the store
      for (int i = 0; i < 520; i++) add_cmd(CMD_ENQ, i % 4, $urandom_range(0, 255));
      add_cmd(CMD_DESTROY, 2, 0);
      for (int i = 0; i < 500; i++) begin
         r = $urandom_range(0, 99);
         q = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, NQ - 1);
         v = $urandom_range(0, 255);
         if (r < 6) add_cmd(CMD_CREATE, q, v);
         else if (r < 10) add_cmd(CMD_DESTROY, q, v);
         else if (r < 55) add_cmd(CMD_ENQ, q, v);
         else add_cmd(CMD_DEQ, q, v);
      end
      for (int i = 0; i < NQ; i++) add_cmd(CMD_DESTROY, i, 0);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (40) @(posedge clock);
      hold_cycles = 300;
   end

   initial begin
      wait (sending_done && expected_replies.size() == 0);
      repeat (2000) @(posedge clock);
      if (mismatches == 0 && expected_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
